// ----- design/rlte_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the raster line trim encoder.
// No dependencies; every other design file but rlte_ram imports this package.
package rlte_pkg;

  // Default row buffer size in bytes (range 1 to 256)
  localparam int MAX_ROW_BYTES_DEF = 128;

  // Row length field, wide enough for the largest buffer (256)
  localparam int ROW_LEN_W = 9;

  // Result word geometry
  localparam int WORD_BYTES = 8;
  localparam int OWORD_W    = 64;
  localparam int OCNT_W     = 4;

  // Stream constants
  localparam logic [7:0]        RASTER_CHR = 8'h62;           // 'b'
  localparam logic [47:0]       SKIP_CMD   = 48'h00_31_59_72_2A_1B;
  localparam logic [OCNT_W-1:0] SKIP_LEN   = 4'd6;
  localparam logic [OCNT_W-1:0] HDR_LEN    = 4'd3;
  localparam logic [OCNT_W-1:0] FULL_CNT   = 4'd8;

  // One finished row handed from the front to the back
  typedef struct packed {
    logic [ROW_LEN_W-1:0] len;   // bytes up to the last nonzero one
    logic                 ovf;   // row lost bytes
    logic                 bank;  // buffer bank that holds the row
  } row_desc_t;

endpackage

// ----- design/rlte_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel input and packed result output.
// Depends on rlte_pkg.
interface rlte_pixel_if;
  import rlte_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;

  modport source (output valid, output pixel_byte, output row_end, input ready);
  modport sink   (input valid, input pixel_byte, input row_end, output ready);
endinterface

interface rlte_word_if;
  import rlte_pkg::*;
  logic               valid;
  logic               ready;
  logic [OWORD_W-1:0] out_word;
  logic [OCNT_W-1:0]  out_count;
  logic               last_of_row;
  logic               overflow;

  modport source (output valid, output out_word, output out_count, output last_of_row,
                  output overflow, input ready);
  modport sink   (input valid, input out_word, input out_count, input last_of_row,
                  input overflow, output ready);
endinterface

// ----- design/rlte_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rlte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/rlte_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts pixel beats, stores them in the row bank, tracks trim length.
// Depends on rlte_pkg and rlte_pixel_if.
module rlte_front #(
  parameter int MAX_ROW_BYTES = rlte_pkg::MAX_ROW_BYTES_DEF,
  parameter int ADDR_W        = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rlte_pixel_if.sink            in_ch,
  output logic                  ram_wr_en,
  output logic [ADDR_W-1:0]     ram_wr_addr,
  output logic [7:0]            ram_wr_data,
  input  logic                  q_full,
  output logic                  q_push,
  output rlte_pkg::row_desc_t   q_desc
);
  import rlte_pkg::*;

  localparam int LEN_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int IDX_W = ADDR_W - 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ROW_BYTES);

  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] lnz_r, lnz_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;

  logic             accept;
  logic             room;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] lnz_upd;
  logic             ovf_upd;

  // A bank is free whenever the queue has space
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = cnt_r < MAX_LEN;
  assign cnt_inc     = cnt_r + LEN_W'(1);

  // Store the beat if the row still fits
  assign ram_wr_en   = accept && room;
  assign ram_wr_addr = {bank_r, cnt_r[IDX_W-1:0]};
  assign ram_wr_data = in_ch.pixel_byte;

  // Track end of last nonzero byte and dropped bytes
  assign lnz_upd = (accept && room && (in_ch.pixel_byte != 8'd0)) ? cnt_inc : lnz_r;
  assign ovf_upd = ovf_r | (accept && !room);

  // Hand the finished row to the back end
  assign q_push      = accept && in_ch.row_end;
  assign q_desc.len  = ROW_LEN_W'(lnz_upd);
  assign q_desc.ovf  = ovf_upd;
  assign q_desc.bank = bank_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    lnz_nxt  = lnz_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (q_push) begin
      cnt_nxt  = '0;
      lnz_nxt  = '0;
      ovf_nxt  = 1'b0;
      bank_nxt = !bank_r;
    end else if (accept) begin
      cnt_nxt = room ? cnt_inc : cnt_r;
      lnz_nxt = lnz_upd;
      ovf_nxt = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lnz_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      lnz_r  <= lnz_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ----- design/rlte_row_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of finished row descriptors between front and back.
// Depends on rlte_pkg. An entry stays at the head until the row's last beat is loaded.
module rlte_row_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rlte_pkg::row_desc_t push_desc,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output rlte_pkg::row_desc_t head_desc
);
  import rlte_pkg::*;

  row_desc_t  slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_desc  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/rlte_back.sv -----
`timescale 1ns / 1ps
// Back end: reads a row one byte a cycle unless the beat is full, packs header and data
// into 8-byte result beats or sends the skip-line command; uses rlte_pkg, rlte_word_if.
module rlte_back #(
  parameter int MAX_ROW_BYTES = rlte_pkg::MAX_ROW_BYTES_DEF,
  parameter int ADDR_W        = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rlte_pkg::row_desc_t q_desc,
  output logic                q_pop,
  output logic                ram_rd_en,
  output logic [ADDR_W-1:0]   ram_rd_addr,
  input  logic [7:0]          ram_rd_data,
  rlte_word_if.source         out_ch
);
  import rlte_pkg::*;

  localparam int LEN_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int IDX_W = ADDR_W - 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DATA = 1'b1;

  logic               state_r, state_nxt;
  logic [LEN_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic               rd_pend_r;
  logic [OWORD_W-1:0] acc_r, acc_nxt;
  logic [OCNT_W-1:0]  acc_cnt_r, acc_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OWORD_W-1:0] out_word_r, out_word_nxt;
  logic [OCNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic [LEN_W-1:0]   row_len;
  logic [15:0]        len16;
  logic               can_load;
  logic               done_all;
  logic               flush;
  logic               skip_load;
  logic               start;
  logic [OWORD_W-1:0] acc0;
  logic [OCNT_W-1:0]  cnt0;
  logic [OWORD_W-1:0] acc_ins;
  logic [OCNT_W-1:0]  cnt_ins;
  logic               issue;

  assign row_len  = LEN_W'(q_desc.len);
  assign len16    = 16'(q_desc.len);
  assign can_load = !out_valid_r || out_ch.ready;

  // Row end: all bytes read and none in flight
  assign done_all  = (rd_ptr_r == row_len) && !rd_pend_r;
  assign flush     = (state_r == ST_DATA) && can_load &&
                     ((acc_cnt_r == FULL_CNT) || done_all);
  assign skip_load = (state_r == ST_IDLE) && q_valid && (row_len == '0) && can_load;
  assign start     = (state_r == ST_IDLE) && q_valid && (row_len != '0);
  assign q_pop     = skip_load || (flush && done_all);

  // Pack: drop flushed bytes, then append the byte returned by the RAM
  assign acc0    = flush ? '0 : acc_r;
  assign cnt0    = flush ? '0 : acc_cnt_r;
  assign acc_ins = rd_pend_r ? (acc0 | (OWORD_W'(ram_rd_data) << {cnt0[2:0], 3'b000}))
                             : acc0;
  assign cnt_ins = cnt0 + OCNT_W'(rd_pend_r);

  // Read only when the byte will find room next cycle
  assign issue       = (state_r == ST_DATA) && (rd_ptr_r != row_len) &&
                       (cnt_ins != FULL_CNT);
  assign ram_rd_en   = issue;
  assign ram_rd_addr = {q_desc.bank, rd_ptr_r[IDX_W-1:0]};

  always_comb begin
    state_nxt   = state_r;
    rd_ptr_nxt  = rd_ptr_r;
    acc_nxt     = acc_r;
    acc_cnt_nxt = acc_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          acc_nxt     = {40'd0, len16[15:8], len16[7:0], RASTER_CHR};
          acc_cnt_nxt = HDR_LEN;
          rd_ptr_nxt  = '0;
          state_nxt   = ST_DATA;
        end
      end
      ST_DATA: begin
        acc_nxt     = acc_ins;
        acc_cnt_nxt = cnt_ins;
        if (issue) begin
          rd_ptr_nxt = rd_ptr_r + LEN_W'(1);
        end
        if (flush && done_all) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: load a beat, or hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (skip_load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = OWORD_W'(SKIP_CMD);
      out_cnt_nxt   = SKIP_LEN;
      out_last_nxt  = 1'b1;
      out_ovf_nxt   = q_desc.ovf;
    end else if (flush) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = acc_r;
      out_cnt_nxt   = acc_cnt_r;
      out_last_nxt  = done_all;
      out_ovf_nxt   = q_desc.ovf;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= issue;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_word    = out_word_r;
  assign out_ch.out_count   = out_cnt_r;
  assign out_ch.last_of_row = out_last_r;
  assign out_ch.overflow    = out_ovf_r;

endmodule

// ----- design/raster_line_trim_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the raster line trim encoder: front, row queue, back, row RAM.
// Depends on rlte_pkg, rlte_if, rlte_ram, rlte_front, rlte_row_queue, rlte_back.
//
//  Channel  Dir  Handshake     Beat contents
//  in_ch    in   valid/ready   pixel_byte, row_end
//  out_ch   out  valid/ready   out_word, out_count, last_of_row, overflow
//
// The front takes one pixel beat per cycle while in_ch.ready is high and writes it to
// one of two row banks. The back reads a row one byte a cycle through the single RAM
// read port while its result beat has room and out_ch is not stalled. A row can fill
// one bank while the back drains the other; in_ch.ready drops while both banks hold
// rows whose last beat has not yet been packed.
// Reset is synchronous and clears control state; no clearing pass over the RAM.
// A stalled result holds in the output register while the front keeps accepting.
module raster_line_trim_encoder #(
  parameter int MAX_ROW_BYTES = rlte_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rlte_pixel_if.sink   in_ch,
  rlte_word_if.source  out_ch
);
  import rlte_pkg::*;

  localparam int IDX_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  row_desc_t         push_desc;
  row_desc_t         head_desc;

  rlte_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .ram_wr_en   (wr_en),
    .ram_wr_addr (wr_addr),
    .ram_wr_data (wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_desc      (push_desc)
  );

  rlte_row_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (push_desc),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  rlte_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rlte_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_desc      (head_desc),
    .q_pop       (q_pop),
    .ram_rd_en   (rd_en),
    .ram_rd_addr (rd_addr),
    .ram_rd_data (rd_data),
    .out_ch      (out_ch)
  );

endmodule

// ----- design/rlte_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the raster line trim encoder, bound to the top level.
// Depends on rlte_pkg.
module rlte_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rlte_pkg::OWORD_W-1:0] out_word,
  input logic [rlte_pkg::OCNT_W-1:0]  out_count,
  input logic                         out_last
);
  import rlte_pkg::*;

  logic first_r;

  // Track the first beat of each row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= out_last;
    end
  end

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_count)
                                && $stable(out_last))
    else $error("stalled result beat changed");

  // Only the last beat of a row may be partly filled
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_count == FULL_CNT)
    else $error("non-final beat not full");

  // Bytes past the count are zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count != 4'd0 && out_count != FULL_CNT
      |-> (out_word >> {out_count[2:0], 3'b000}) == '0)
    else $error("nonzero byte past count");

  // A row not starting with the raster command is the skip-line command
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r && out_word[7:0] != RASTER_CHR
      |-> out_last && out_count == SKIP_LEN && out_word == OWORD_W'(SKIP_CMD))
    else $error("malformed skip-line result");

endmodule

bind raster_line_trim_encoder rlte_checker u_rlte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.out_word),
  .out_count (out_ch.out_count),
  .out_last  (out_ch.last_of_row)
);
